// File: sv/itdt_pkg.sv
package itdt_pkg;

    // Table geometry and word sizes.
    localparam int TABLE_DEPTH = 256;
    localparam int MAX_ATTRS   = 4;
    localparam int INDEX_BITS  = 16;
    localparam int WORDS       = 4;

    localparam int SLOT_BITS  = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS = SLOT_BITS + 1;
    localparam int LEN_BITS   = 3;

    // Largest number of words that can take part in a comparison.
    localparam int LEN_LIMIT = (MAX_ATTRS < WORDS) ? MAX_ATTRS : WORDS;

    typedef logic [INDEX_BITS-1:0] t_word;
    typedef t_word [WORDS-1:0]     t_tuple;
    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [LEN_BITS-1:0]   t_len;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic hit;
        logic miss;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic cmp_valid;
        logic match;
    } t_status;

endpackage

// File: sv/itdt_ctrl.sv
module itdt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  itdt_pkg::t_status i_status,
    output itdt_pkg::t_cmd   o_cmd,
    output logic             busy
);
    import itdt_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   n_busy;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = ST_IDLE;
                end else if (i_status.scan_done && !i_status.cmp_valid) begin
                    o_cmd.miss = 1'b1;
                    n_state    = ST_IDLE;
                end else if (!i_status.scan_done) begin
                    o_cmd.issue = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    // State and the registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            busy    <= 1'b0;
        end else begin
            r_state <= n_state;
            busy    <= n_busy;
        end
    end

endmodule

// File: sv/itdt_datapath.sv
module itdt_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  itdt_pkg::t_cmd            i_cmd,
    output itdt_pkg::t_status         o_status,
    input  logic                      i_cfg_we,
    input  logic [itdt_pkg::LEN_BITS-1:0]   i_cfg_wdata,
    input  logic                      i_new_model,
    input  itdt_pkg::t_tuple          i_tuple,
    output logic [itdt_pkg::SLOT_BITS-1:0]  o_vertex_index,
    output logic                      o_is_new,
    output logic                      o_table_full,
    output logic [itdt_pkg::COUNT_BITS-1:0] o_unique_count,
    output logic                      o_done
);
    import itdt_pkg::*;

    t_tuple r_mem [TABLE_DEPTH];

    t_len   r_attr_count;
    t_tuple r_tuple;
    t_count r_count;
    t_count r_scan;
    t_tuple r_rd_data;
    t_slot  r_cmp_slot;
    logic   r_cmp_valid;
    t_len   eff_len;
    logic   equal;
    logic   room;

    // Effective comparison length: zero counts as one, large values clip.
    always_comb begin
        eff_len = r_attr_count;
        if (r_attr_count == '0) begin
            eff_len = t_len'(1);
        end else if (r_attr_count > t_len'(LEN_LIMIT)) begin
            eff_len = t_len'(LEN_LIMIT);
        end
    end

    // Compare the entry read from the table against the held tuple over the first eff_len words.
    always_comb begin
        equal = 1'b1;
        for (int k = 0; k < WORDS; k++) begin
            if (t_len'(k) < eff_len && r_rd_data[k] != r_tuple[k]) begin
                equal = 1'b0;
            end
        end
    end

    assign room = (r_count < t_count'(TABLE_DEPTH));

    assign o_status.scan_done = (r_scan >= r_count);
    assign o_status.cmp_valid = r_cmp_valid;
    assign o_status.match     = r_cmp_valid && equal;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_count <= t_len'(1);
        end else if (i_cfg_we) begin
            r_attr_count <= i_cfg_wdata;
        end
    end

    // Count, scan pointer and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan      <= '0;
            r_cmp_valid <= 1'b0;
            o_done      <= 1'b0;
        end else begin
            o_done      <= i_cmd.hit || i_cmd.miss;
            r_cmp_valid <= i_cmd.issue;
            if (i_cmd.load) begin
                r_scan <= '0;
                if (i_new_model) begin
                    r_count <= '0;
                end
            end else if (i_cmd.issue) begin
                r_scan <= r_scan + t_count'(1);
            end
            if (i_cmd.miss && room) begin
                r_count <= r_count + t_count'(1);
            end
        end
    end

    // Held tuple, table read and write, and result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tuple <= i_tuple;
        end
        if (i_cmd.issue) begin
            r_rd_data  <= r_mem[r_scan[SLOT_BITS-1:0]];
            r_cmp_slot <= r_scan[SLOT_BITS-1:0];
        end
        if (i_cmd.miss && room) begin
            r_mem[r_count[SLOT_BITS-1:0]] <= r_tuple;
        end
        if (i_cmd.hit) begin
            o_vertex_index <= r_cmp_slot;
            o_is_new       <= 1'b0;
            o_table_full   <= 1'b0;
            o_unique_count <= r_count;
        end else if (i_cmd.miss) begin
            if (room) begin
                o_vertex_index <= r_count[SLOT_BITS-1:0];
                o_is_new       <= 1'b1;
                o_table_full   <= 1'b0;
                o_unique_count <= r_count + t_count'(1);
            end else begin
                o_vertex_index <= '0;
                o_is_new       <= 1'b0;
                o_table_full   <= 1'b1;
                o_unique_count <= r_count;
            end
        end
    end

endmodule

// File: sv/index_tuple_dedup_table.sv
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    i_new_model, i_attr_index_0..3
// result    out        o_done, one cycle       o_vertex_index, o_is_new,
//                                              o_table_full, o_unique_count
// config    in         i_cfg_we                i_cfg_wdata (attr_count)
//
// The table is scanned one slot per cycle through a registered read. o_done
// is registered from the hit or miss decision: a hit once the matching slot's
// compare is seen, a miss once every stored slot has been compared with no
// match, or with no compare at all when the table is empty.
// busy falls as o_done rises, so the next word may start in that cycle.
// Reset is synchronous and active low; it empties the table (count to zero)
// and sets attr_count to 1. The receiver cannot stall: o_done lasts one cycle.
module index_tuple_dedup_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_new_model,
    input  logic [15:0] i_attr_index_0,
    input  logic [15:0] i_attr_index_1,
    input  logic [15:0] i_attr_index_2,
    input  logic [15:0] i_attr_index_3,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [7:0]  o_vertex_index,
    output logic        o_is_new,
    output logic        o_table_full,
    output logic [8:0]  o_unique_count
);
    import itdt_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_tuple  tuple;

    // Gather the index words into one tuple.
    assign tuple[0] = i_attr_index_0[INDEX_BITS-1:0];
    assign tuple[1] = i_attr_index_1[INDEX_BITS-1:0];
    assign tuple[2] = i_attr_index_2[INDEX_BITS-1:0];
    assign tuple[3] = i_attr_index_3[INDEX_BITS-1:0];

    itdt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    itdt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_new_model    (i_new_model),
        .i_tuple        (tuple),
        .o_vertex_index (o_vertex_index),
        .o_is_new       (o_is_new),
        .o_table_full   (o_table_full),
        .o_unique_count (o_unique_count),
        .o_done         (o_done)
    );

endmodule

// File: test/tb_index_tuple_dedup_table.sv
module tb_index_tuple_dedup_table;

    import itdt_pkg::*;

    // One lookup answer as the block reports it.
    typedef struct packed {
        t_slot  slot;
        logic   fresh;
        logic   full;
        t_count count;
    } t_dedup_answer;

    // One directed row: an optional attr_count write, then one word.
    // When fixed is set, ans is the answer read straight off the behavior.
    typedef struct packed {
        logic          cfg_we;
        t_len          cfg;
        logic          nm;
        t_word         w0;
        t_word         w1;
        t_word         w2;
        t_word         w3;
        logic          fixed;
        t_dedup_answer ans;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 19;
    localparam int RANDOM_WORDS  = 1900;
    localparam int POOL_SIZE     = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_new_model;
    logic [15:0] i_attr_index_0;
    logic [15:0] i_attr_index_1;
    logic [15:0] i_attr_index_2;
    logic [15:0] i_attr_index_3;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;
    logic        o_done;
    logic [7:0]  o_vertex_index;
    logic        o_is_new;
    logic        o_table_full;
    logic [8:0]  o_unique_count;

    // Our own copy of the unique table and its settings.
    t_tuple      known_tuples [TABLE_DEPTH];
    int unsigned known_count;
    t_len        attr_cfg;

    t_dedup_answer pending_answers [$];
    int            mismatches;
    int            random_sent;
    bit            steady;
    t_word         word_pool [WORDS][POOL_SIZE];
    int            pool_n;

    // Directed rows. Expected answers follow the slot history in order:
    // all-zero and all-one tuples, attr_count of zero and above the limit,
    // hidden words compared after a wider setting, and new_model clears.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
        '{1'b0, 3'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
        '{1'b0, 3'd0, 1'b0, 16'h0000, 16'hFFFF, 16'h1234, 16'h5678,
          1'b1, '{8'd0, 1'b0, 1'b0, 9'd2}},
        '{1'b1, 3'd4, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, '{8'd2, 1'b1, 1'b0, 9'd3}},
        '{1'b1, 3'd0, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
          1'b1, '{8'd1, 1'b0, 1'b0, 9'd3}},
        '{1'b1, 3'd7, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, '{8'd1, 1'b0, 1'b0, 9'd3}},
        '{1'b0, 3'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE,
          1'b1, '{8'd3, 1'b1, 1'b0, 9'd4}},
        '{1'b1, 3'd2, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
          1'b1, '{8'd1, 1'b0, 1'b0, 9'd4}},
        '{1'b1, 3'd3, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hAAAA,
          1'b1, '{8'd2, 1'b0, 1'b0, 9'd4}},
        '{1'b1, 3'd5, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hAAAA,
          1'b1, '{8'd4, 1'b1, 1'b0, 9'd5}},
        '{1'b0, 3'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
        '{1'b0, 3'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
        '{1'b0, 3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, '{8'd0, 1'b0, 1'b0, 9'd1}},
        '{1'b1, 3'd6, 1'b0, 16'h8000, 16'h4000, 16'h2000, 16'h1000,
          1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
        '{1'b1, 3'd1, 1'b0, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, '{8'd1, 1'b0, 1'b0, 9'd2}},
        '{1'b0, 3'd0, 1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
          1'b1, '{8'd2, 1'b1, 1'b0, 9'd3}},
        '{1'b0, 3'd0, 1'b1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
          1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
        '{1'b0, 3'd0, 1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
          1'b0, '0},
        '{1'b1, 3'd2, 1'b0, 16'hAAAA, 16'h5555, 16'h0000, 16'h0000,
          1'b0, '0}
    };

    index_tuple_dedup_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_new_model    (i_new_model),
        .i_attr_index_0 (i_attr_index_0),
        .i_attr_index_1 (i_attr_index_1),
        .i_attr_index_2 (i_attr_index_2),
        .i_attr_index_3 (i_attr_index_3),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_vertex_index (o_vertex_index),
        .o_is_new       (o_is_new),
        .o_table_full   (o_table_full),
        .o_unique_count (o_unique_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Searches the table in slot order and appends on a miss.
    function automatic t_dedup_answer predict_lookup(input logic nm, input t_tuple tup);
        t_dedup_answer a;
        int unsigned   len;
        bit            hit;
        a   = '0;
        hit = 1'b0;
        len = (attr_cfg < 1) ? 1 : attr_cfg;
        if (len > LEN_LIMIT) len = LEN_LIMIT;
        if (nm) known_count = 0;
        for (int s = 0; s < known_count && !hit; s++) begin
            bit same;
            same = 1'b1;
            for (int k = 0; k < len; k++) begin
                if (known_tuples[s][k] != tup[k]) same = 1'b0;
            end
            if (same) begin
                hit    = 1'b1;
                a.slot = t_slot'(s);
            end
        end
        if (!hit) begin
            if (known_count < TABLE_DEPTH) begin
                a.slot = t_slot'(known_count);
                known_tuples[known_count] = tup;
                known_count++;
                a.fresh = 1'b1;
            end else begin
                a.full = 1'b1;
            end
        end
        a.count = t_count'(known_count);
        return a;
    endfunction

    // Presents one word and holds it until the block takes it.
    task automatic send_tuple(input logic nm, input t_tuple tup, input logic fixed,
                              input t_dedup_answer fixed_ans);
        t_dedup_answer ans;
        start          <= 1'b1;
        i_new_model    <= nm;
        i_attr_index_0 <= tup[0];
        i_attr_index_1 <= tup[1];
        i_attr_index_2 <= tup[2];
        i_attr_index_3 <= tup[3];
        do @(posedge i_clk); while (busy !== 1'b0);
        ans = predict_lookup(nm, tup);
        pending_answers.insert(pending_answers.size(), fixed ? fixed_ans : ans);
    endtask

    // Random gap after a word, unless this stretch runs without idling.
    task automatic sender_gap();
        if (!steady && $urandom_range(0, 99) < 32) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Holds off new words until every answer has come back.
    task automatic drain_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_attr_count(input t_len value);
        drain_answers();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        attr_cfg = value;
    endtask

    // Fills all slots with distinct leading words, then pushes past the end.
    task automatic fill_table();
        t_word  base;
        t_word  stride;
        t_tuple tup;
        base   = t_word'($urandom);
        stride = t_word'($urandom) | 16'h0001;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tup    = t_tuple'({$urandom, $urandom});
            tup[0] = t_word'(base + i * stride);
            send_tuple(i == 0, tup, 1'b0, '0);
            sender_gap();
        end
        for (int i = 0; i < 24; i++) begin
            if ($urandom_range(0, 1) == 0)
                tup = known_tuples[$urandom_range(0, TABLE_DEPTH - 1)];
            else
                tup = t_tuple'({$urandom, $urandom});
            send_tuple(1'b0, tup, 1'b0, '0);
            sender_gap();
        end
        random_sent += TABLE_DEPTH + 24;
    endtask

    // A burst of words drawn mostly from small pools so that hits are common.
    task automatic random_burst(input int n);
        t_tuple tup;
        logic   nm;
        for (int i = 0; i < n; i++) begin
            nm = ($urandom_range(0, 39) == 0);
            for (int k = 0; k < WORDS; k++) begin
                if ($urandom_range(0, 99) < 12)
                    tup[k] = t_word'($urandom);
                else
                    tup[k] = word_pool[k][$urandom_range(0, pool_n - 1)];
            end
            send_tuple(nm, tup, 1'b0, '0);
            if ($urandom_range(0, 99) == 0) drain_answers();
            else sender_gap();
        end
        random_sent += n;
    endtask

    task automatic refill_pool();
        int pick;
        pool_n = $urandom_range(2, POOL_SIZE);
        for (int k = 0; k < WORDS; k++) begin
            for (int j = 0; j < POOL_SIZE; j++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) word_pool[k][j] = '0;
                else if (pick == 1) word_pool[k][j] = '1;
                else word_pool[k][j] = t_word'($urandom);
            end
        end
    endtask

    // Main stimulus: reset, directed rows, then random phases.
    initial begin
        t_directed_row row;
        int            phase;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_new_model    <= 1'b0;
        i_attr_index_0 <= '0;
        i_attr_index_1 <= '0;
        i_attr_index_2 <= '0;
        i_attr_index_3 <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        known_count = 0;
        attr_cfg    = t_len'(1);
        mismatches  = 0;
        random_sent = 0;
        steady      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_rows[r];
            if (row.cfg_we) write_attr_count(row.cfg);
            send_tuple(row.nm, {row.w3, row.w2, row.w1, row.w0}, row.fixed, row.ans);
            sender_gap();
        end

        // Early phases hit the register extremes; two phases fill the table.
        phase = 0;
        while (random_sent < RANDOM_WORDS) begin
            if (phase == 0) write_attr_count(t_len'(0));
            else if (phase == 1) write_attr_count(t_len'(7));
            else write_attr_count(t_len'($urandom_range(0, 7)));
            steady = (phase == 4);
            if (phase == 2 || phase == 7) begin
                fill_table();
            end else begin
                refill_pool();
                random_burst($urandom_range(100, 200));
            end
            phase++;
        end

        drain_answers();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $display("%0t: %0d answers never arrived", $time, pending_answers.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Each answer is taken on the edge that ends its o_done cycle.
    always @(posedge i_clk) begin
        t_dedup_answer want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: answer with no word waiting, expected none, got slot %0d",
                         $time, o_vertex_index);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (o_vertex_index !== want.slot) begin
                    $display("%0t: vertex_index expected %0d got %0d",
                             $time, want.slot, o_vertex_index);
                    mismatches++;
                end
                if (o_is_new !== want.fresh) begin
                    $display("%0t: is_new expected %0d got %0d", $time, want.fresh, o_is_new);
                    mismatches++;
                end
                if (o_table_full !== want.full) begin
                    $display("%0t: table_full expected %0d got %0d",
                             $time, want.full, o_table_full);
                    mismatches++;
                end
                if (o_unique_count !== want.count) begin
                    $display("%0t: unique_count expected %0d got %0d",
                             $time, want.count, o_unique_count);
                    mismatches++;
                end
            end
        end
    end

    // A hung handshake ends the run here.
    initial begin
        #12000000;
        $display("status: fail");
        $finish;
    end

endmodule
